### design/qslerp_pkg.sv
package qslerp_pkg;

  localparam int FRAC_BITS = 14;
  localparam int D_SHIFT = 30 - 2 * FRAC_BITS;
  localparam int CW = 36;
  localparam int DW = 72;
  localparam int QW = 41;
  localparam int WW = 43;

  localparam logic [32:0] D_MAX = 33'(64'd1 << (30 - D_SHIFT));
  localparam logic [63:0] Q60 = 64'd1 << 60;
  localparam logic signed [CW-1:0] Q30_ONE = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] Q30_PI = CW'(64'sd3373259426);
  localparam logic signed [CW-1:0] Q30_HALF_PI = CW'(64'sd1686629713);
  localparam logic [QW-1:0] WLIMIT = QW'(64'd1 << 40);

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    logic [16:0]      t;
    logic [32:0]      mag;
    logic             flip;
    logic             linear;
  } q_item_t;

  typedef struct packed {
    logic [3:0][15:0] r;
    logic             took_linear;
  } r_item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cw_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } dv_t;

  function automatic logic signed [CW-1:0] atan_step(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0: v = CW'(843314857);
      1: v = CW'(497837829);
      2: v = CW'(263043837);
      3: v = CW'(133525159);
      4: v = CW'(67021687);
      5: v = CW'(33543516);
      6: v = CW'(16775851);
      7: v = CW'(8388437);
      8: v = CW'(4194283);
      9: v = CW'(2097149);
      default: v = (i <= 30) ? CW'(64'd1 << (30 - i)) : '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CW-1:0] fold_angle(input logic signed [CW-1:0] ang);
    logic signed [CW-1:0] r;
    r = ang;
    if (ang > Q30_HALF_PI) begin
      r = Q30_PI - ang;
    end else if (ang < -Q30_HALF_PI) begin
      r = -Q30_PI - ang;
    end
    return r;
  endfunction

  function automatic cw_t vec_step(input cw_t c, input int i);
    cw_t r;
    logic signed [CW-1:0] x, y, z, dx, dy, at;
    x = c.x;
    y = c.y;
    z = c.z;
    dx = y >>> i;
    dy = x >>> i;
    at = atan_step(i);
    if (y > 0) begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + at;
    end else begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - at;
    end
    return r;
  endfunction

  function automatic cw_t rot_step(input cw_t c, input int i);
    cw_t r;
    logic signed [CW-1:0] x, y, z, dx, dy, at;
    x = c.x;
    y = c.y;
    z = c.z;
    dx = y >>> i;
    dy = x >>> i;
    at = atan_step(i);
    if (z >= 0) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - at;
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + at;
    end
    return r;
  endfunction

  function automatic dv_t div_step(input dv_t l, input logic [CW-1:0] den, input int k);
    dv_t r;
    logic [DW-1:0] dk;
    r = l;
    dk = DW'(den) << k;
    if (l.rem >= dk) begin
      r.rem = l.rem - dk;
      r.q[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [WW-1:0] sine_weight(input dv_t l);
    logic [QW-1:0] m;
    logic signed [WW-1:0] w;
    m = (l.ovf || l.q > WLIMIT) ? WLIMIT : l.q;
    w = $signed(WW'(m));
    return l.neg ? -w : w;
  endfunction

endpackage

### design/quaternion_slerp.sv
// Quaternion spherical linear interpolation, Q2.14 components, Q1.16 blend.
// Input side looks like a queue: drive a_*, b_* and blend_t with push; the
// transaction is taken at a rising edge with push high and full low.
// Result side: while empty is low, r_* and took_linear show the oldest
// result; pop with empty low takes it.
// Configuration: near_threshold is written at an edge with cfg_valid and
// cfg_ready high (cfg_ready is always high); write only while idle.
// From push to empty going low, a transaction passes the square root,
// three CORDIC chains and the 41-step weight divider, each one pipeline
// stage per step. Throughput: one transaction per cycle while results
// are popped; a result side that stops popping stalls the flow.
// A receiver that stops popping fills the two-entry result queue; the
// back pipeline then freezes, the four-entry mid queue fills, and full
// rises. Nothing is dropped. Reset empties both queues and the pipeline
// and sets near_threshold to 16383.
module quaternion_slerp #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] a_x,
  input  logic signed [15:0] a_y,
  input  logic signed [15:0] a_z,
  input  logic signed [15:0] a_w,
  input  logic signed [15:0] b_x,
  input  logic signed [15:0] b_y,
  input  logic signed [15:0] b_z,
  input  logic signed [15:0] b_w,
  input  logic [16:0]        blend_t,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] r_x,
  output logic signed [15:0] r_y,
  output logic signed [15:0] r_z,
  output logic signed [15:0] r_w,
  output logic               took_linear,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);
  import qslerp_pkg::*;

  logic [14:0] near_threshold;
  logic [3:0][15:0] a_vec;
  logic [3:0][15:0] b_vec;
  q_item_t q_wdata;
  q_item_t q_rdata;
  logic q_wr;
  logic q_full;
  logic q_empty;
  logic q_rd;
  r_item_t oq_wdata;
  r_item_t oq_rdata;
  logic oq_wr;
  logic oq_full;
  logic oq_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= 15'd16383;
    end else if (cfg_valid && cfg_ready) begin
      near_threshold <= cfg_data;
    end
  end

  assign a_vec = {a_w, a_z, a_y, a_x};
  assign b_vec = {b_w, b_z, b_y, b_x};

  qslerp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .a              (a_vec),
    .b              (b_vec),
    .t              (blend_t),
    .near_threshold (near_threshold),
    .q_data         (q_wdata),
    .q_wr           (q_wr),
    .q_full         (q_full)
  );

  qslerp_fifo #(
    .WIDTH ($bits(q_item_t)),
    .DEPTH (4)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  qslerp_back #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_data  (q_rdata),
    .in_valid (!q_empty),
    .in_pop   (q_rd),
    .out_data (oq_wdata),
    .out_wr   (oq_wr),
    .out_room (!oq_full || oq_rd)
  );

  assign oq_rd = pop && !empty;

  qslerp_fifo #(
    .WIDTH ($bits(r_item_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_wr),
    .wr_data (oq_wdata),
    .full    (oq_full),
    .rd_en   (oq_rd),
    .rd_data (oq_rdata),
    .empty   (empty)
  );

  assign r_x = oq_rdata.r[0];
  assign r_y = oq_rdata.r[1];
  assign r_z = oq_rdata.r[2];
  assign r_w = oq_rdata.r[3];
  assign took_linear = oq_rdata.took_linear;

  a_mid_no_ovf: assert property (@(posedge clk) disable iff (rst)
    q_wr |-> !q_full)
    else $error("mid queue written while full");

  a_out_no_ovf: assert property (@(posedge clk) disable iff (rst)
    oq_wr && oq_full |-> oq_rd)
    else $error("result queue written while full without a pop");

endmodule

### design/qslerp_fifo.sv
module qslerp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  assign full = (count == (AW + 1)'(DEPTH));
  assign empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/qslerp_front.sv
module qslerp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [3:0][15:0]     a,
  input  logic [3:0][15:0]     b,
  input  logic [16:0]          t,
  input  logic [14:0]          near_threshold,
  output qslerp_pkg::q_item_t  q_data,
  output logic                 q_wr,
  input  logic                 q_full
);
  import qslerp_pkg::*;

  logic f_valid;
  logic signed [31:0] prod [4];
  logic [3:0][15:0] fa;
  logic [3:0][15:0] fb;
  logic [16:0] ft;
  logic signed [33:0] dot;
  logic [32:0] mag_c;

  assign full = f_valid && q_full;
  assign q_wr = f_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!full) begin
      f_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      fa <= a;
      fb <= b;
      ft <= t;
      for (int k = 0; k < 4; k++) begin
        prod[k] <= $signed(a[k]) * $signed(b[k]);
      end
    end
  end

  always_comb begin
    dot = '0;
    for (int k = 0; k < 4; k++) begin
      dot = dot + 34'(prod[k]);
    end
    mag_c = dot[33] ? 33'(-dot) : 33'(dot);
  end

  assign q_data = '{a: fa, b: fb, t: ft, mag: mag_c, flip: dot[33],
                    linear: mag_c > 33'({near_threshold, {FRAC_BITS{1'b0}}})};

endmodule

### design/qslerp_back.sv
module qslerp_back #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  qslerp_pkg::q_item_t  in_data,
  input  logic                 in_valid,
  output logic                 in_pop,
  output qslerp_pkg::r_item_t  out_data,
  output logic                 out_wr,
  input  logic                 out_room
);
  import qslerp_pkg::*;

  localparam int T = TRIG_ITERATIONS;
  localparam int NRT = 32;
  localparam int NDV = QW;
  localparam int S_RT0 = 3;
  localparam int S_AN0 = S_RT0 + NRT;
  localparam int S_FD = S_AN0 + T;
  localparam int S_SN0 = S_FD + 1;
  localparam int S_W = S_SN0 + T;
  localparam int S_A = S_W + 1;
  localparam int S_SW0 = S_A + 1;
  localparam int S_V = S_SW0 + T;
  localparam int S_DV0 = S_V + 1;
  localparam int S_WT = S_DV0 + NDV;
  localparam int LAST = S_WT + 1;
  localparam int PW = 18 + CW;
  localparam int PRW = WW + 16;
  localparam int AW2 = PRW + 1;

  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][15:0] b;
    logic [16:0]      t;
    logic             flip;
    logic             linear;
  } meta_t;

  logic go;
  logic [LAST:0] vld;
  meta_t meta [LAST];

  logic [32:0] ld_mag;
  logic [30:0] d_cl;
  logic [61:0] sq_c;
  logic [61:0] sq1;
  logic [30:0] d1;
  logic [63:0] n2;
  logic [30:0] d2;

  logic [63:0] rt_rem [NRT];
  logic [63:0] rt_root [NRT];
  logic [30:0] rt_d [NRT];

  cw_t an [T];
  logic signed [CW-1:0] fd_theta;
  logic signed [CW-1:0] fd_ang;
  cw_t sn [T];
  logic signed [CW-1:0] sn_theta [T];

  logic signed [17:0] m1_c;
  logic signed [17:0] m2_c;
  logic signed [PW-1:0] w_p1;
  logic signed [PW-1:0] w_p2;
  logic signed [CW-1:0] w_sth;
  logic signed [PW-1:0] r1_c;
  logic signed [PW-1:0] r2_c;
  logic signed [CW-1:0] a_ang1;
  logic signed [CW-1:0] a_ang2;
  logic signed [CW-1:0] a_sth;

  cw_t sw1 [T];
  cw_t sw2 [T];
  logic signed [CW-1:0] sw_sth [T];

  logic signed [CW-1:0] y1_c;
  logic signed [CW-1:0] y2_c;
  logic [CW-1:0] mg1_c;
  logic [CW-1:0] mg2_c;
  logic [CW-1:0] den_c;
  dv_t v1;
  dv_t v2;
  logic [CW-1:0] v_den;
  logic v_sdeg;
  dv_t dv1 [NDV];
  dv_t dv2 [NDV];
  logic [CW-1:0] dv_den [NDV];
  logic dv_sdeg [NDV];

  meta_t mw;
  logic lin_c;
  logic signed [WW-1:0] w1_c;
  logic signed [WW-1:0] w2_c;
  logic signed [WW-1:0] wt_w1;
  logic signed [WW-1:0] wt_w2;
  logic wt_lin;

  logic signed [PRW-1:0] pr_a [4];
  logic signed [PRW-1:0] pr_b [4];
  logic pr_lin;
  logic signed [AW2-1:0] acc [4];
  logic signed [AW2-1:0] rnd [4];

  assign go = !vld[LAST] || out_room;
  assign in_pop = go && in_valid;
  assign out_wr = vld[LAST] && go;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (go) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      meta[0] <= '{a: in_data.a, b: in_data.b, t: in_data.t,
                   flip: in_data.flip, linear: in_data.linear};
      ld_mag <= in_data.mag;
    end
  end

  for (genvar k = 1; k < LAST; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (go) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  assign d_cl = (ld_mag > D_MAX) ? 31'(Q30_ONE) : 31'(ld_mag << D_SHIFT);
  assign sq_c = d_cl * d_cl;

  always_ff @(posedge clk) begin
    if (go) begin
      sq1 <= sq_c;
      d1 <= d_cl;
      n2 <= Q60 - 64'(sq1);
      d2 <= d1;
    end
  end

  for (genvar i = 0; i < NRT; i++) begin : g_rt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * i);
    logic [63:0] rem_in;
    logic [63:0] root_in;
    logic [63:0] trial;
    logic [30:0] d_in;
    if (i == 0) begin : g_first
      assign rem_in = n2;
      assign root_in = '0;
      assign d_in = d2;
    end else begin : g_next
      assign rem_in = rt_rem[i-1];
      assign root_in = rt_root[i-1];
      assign d_in = rt_d[i-1];
    end
    assign trial = root_in + BITV;
    always_ff @(posedge clk) begin
      if (go) begin
        if (rem_in >= trial) begin
          rt_rem[i] <= rem_in - trial;
          rt_root[i] <= (root_in >> 1) + BITV;
        end else begin
          rt_rem[i] <= rem_in;
          rt_root[i] <= root_in >> 1;
        end
        rt_d[i] <= d_in;
      end
    end
  end

  for (genvar i = 0; i < T; i++) begin : g_an
    cw_t c_in;
    if (i == 0) begin : g_first
      assign c_in = '{x: CW'(rt_d[NRT-1]), y: CW'(rt_root[NRT-1]), z: '0};
    end else begin : g_next
      assign c_in = an[i-1];
    end
    always_ff @(posedge clk) begin
      if (go) begin
        an[i] <= vec_step(c_in, i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      fd_theta <= an[T-1].z;
      fd_ang <= fold_angle(an[T-1].z);
    end
  end

  for (genvar i = 0; i < T; i++) begin : g_sn
    cw_t c_in;
    logic signed [CW-1:0] th_in;
    if (i == 0) begin : g_first
      assign c_in = '{x: Q30_ONE, y: '0, z: fd_ang};
      assign th_in = fd_theta;
    end else begin : g_next
      assign c_in = sn[i-1];
      assign th_in = sn_theta[i-1];
    end
    always_ff @(posedge clk) begin
      if (go) begin
        sn[i] <= rot_step(c_in, i);
        sn_theta[i] <= th_in;
      end
    end
  end

  assign m1_c = 18'sd65536 - $signed({1'b0, meta[S_W-1].t});
  assign m2_c = $signed({1'b0, meta[S_W-1].t});

  always_ff @(posedge clk) begin
    if (go) begin
      w_p1 <= m1_c * sn_theta[T-1];
      w_p2 <= m2_c * sn_theta[T-1];
      w_sth <= sn[T-1].y;
    end
  end

  assign r1_c = (w_p1 + PW'(32768)) >>> 16;
  assign r2_c = (w_p2 + PW'(32768)) >>> 16;

  always_ff @(posedge clk) begin
    if (go) begin
      a_ang1 <= fold_angle(r1_c[CW-1:0]);
      a_ang2 <= fold_angle(r2_c[CW-1:0]);
      a_sth <= w_sth;
    end
  end

  for (genvar i = 0; i < T; i++) begin : g_sw
    cw_t c1_in;
    cw_t c2_in;
    logic signed [CW-1:0] s_in;
    if (i == 0) begin : g_first
      assign c1_in = '{x: Q30_ONE, y: '0, z: a_ang1};
      assign c2_in = '{x: Q30_ONE, y: '0, z: a_ang2};
      assign s_in = a_sth;
    end else begin : g_next
      assign c1_in = sw1[i-1];
      assign c2_in = sw2[i-1];
      assign s_in = sw_sth[i-1];
    end
    always_ff @(posedge clk) begin
      if (go) begin
        sw1[i] <= rot_step(c1_in, i);
        sw2[i] <= rot_step(c2_in, i);
        sw_sth[i] <= s_in;
      end
    end
  end

  assign y1_c = sw1[T-1].y;
  assign y2_c = sw2[T-1].y;
  assign mg1_c = (y1_c < 0) ? -y1_c : y1_c;
  assign mg2_c = (y2_c < 0) ? -y2_c : y2_c;
  assign den_c = sw_sth[T-1];

  always_ff @(posedge clk) begin
    if (go) begin
      v1 <= '{rem: DW'(mg1_c) << 30, q: '0, neg: y1_c < 0,
              ovf: DW'(mg1_c) >= (DW'(den_c) << 11)};
      v2 <= '{rem: DW'(mg2_c) << 30, q: '0, neg: y2_c < 0,
              ovf: DW'(mg2_c) >= (DW'(den_c) << 11)};
      v_den <= den_c;
      v_sdeg <= (sw_sth[T-1] <= 0);
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_dv
    dv_t l1_in;
    dv_t l2_in;
    logic [CW-1:0] den_in;
    logic sdeg_in;
    if (j == 0) begin : g_first
      assign l1_in = v1;
      assign l2_in = v2;
      assign den_in = v_den;
      assign sdeg_in = v_sdeg;
    end else begin : g_next
      assign l1_in = dv1[j-1];
      assign l2_in = dv2[j-1];
      assign den_in = dv_den[j-1];
      assign sdeg_in = dv_sdeg[j-1];
    end
    always_ff @(posedge clk) begin
      if (go) begin
        dv1[j] <= div_step(l1_in, den_in, NDV - 1 - j);
        dv2[j] <= div_step(l2_in, den_in, NDV - 1 - j);
        dv_den[j] <= den_in;
        dv_sdeg[j] <= sdeg_in;
      end
    end
  end

  assign mw = meta[S_WT-1];
  assign lin_c = mw.linear || dv_sdeg[NDV-1];

  always_comb begin
    if (lin_c) begin
      w1_c = WW'(18'sd65536 - $signed({1'b0, mw.t})) <<< 14;
      w2_c = WW'($signed({1'b0, mw.t})) <<< 14;
    end else begin
      w1_c = sine_weight(dv1[NDV-1]);
      w2_c = sine_weight(dv2[NDV-1]);
    end
    if (mw.flip) begin
      w2_c = -w2_c;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      wt_w1 <= w1_c;
      wt_w2 <= w2_c;
      wt_lin <= lin_c;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int k = 0; k < 4; k++) begin
        pr_a[k] <= wt_w1 * $signed(meta[LAST-1].a[k]);
        pr_b[k] <= wt_w2 * $signed(meta[LAST-1].b[k]);
      end
      pr_lin <= wt_lin;
    end
  end

  always_comb begin
    out_data.took_linear = pr_lin;
    for (int k = 0; k < 4; k++) begin
      acc[k] = AW2'(pr_a[k]) + AW2'(pr_b[k]) + AW2'(1 << 29);
      rnd[k] = acc[k] >>> 30;
      if (rnd[k] > AW2'(32767)) begin
        out_data.r[k] = 16'h7fff;
      end else if (rnd[k] < -AW2'(32768)) begin
        out_data.r[k] = 16'h8000;
      end else begin
        out_data.r[k] = rnd[k][15:0];
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && !go |=> vld[LAST])
    else $error("stalled result lost from last stage");

  a_pop_load: assert property (@(posedge clk) disable iff (rst)
    in_pop |=> vld[0])
    else $error("popped transaction not loaded into first stage");

endmodule
